// ===== rtl/core/lps_pkg.sv =====
// Shared types and constants of the lottery process selector.
// No dependencies; every other file of the block imports it.
package lps_pkg;

   localparam int WORD_W      = 32;  // raw random word
   localparam int TICKET_IN_W = 16;  // ticket field on the request port
   localparam int IDX_IN_W    = 6;   // entry index on the request port
   localparam int IDX_OUT_W   = 6;   // winner index on the response port
   localparam int TOTAL_OUT_W = 22;  // total tickets on the response port

   localparam logic KIND_SET  = 1'b0;
   localparam logic KIND_PICK = 1'b1;

   // Per-cell control: load one entry from the request, or rotate the ring.
   typedef struct packed {
      logic write;
      logic shift;
   } cell_ctrl_type;

   // Control of the serial modulo unit.
   typedef struct packed {
      logic load;   // latch the dividend
      logic start;  // begin the bit-serial reduction
   } mod_ctrl_type;

endpackage

// ===== rtl/core/lottery_process_selector.sv =====
// Top level of the lottery process selector: entry ring, scan control, responses.
// Depends on lps_pkg, lps_cell and lps_mod_unit.
//
//   channel  direction  transfer when          carries
//   req_     in         req_valid & req_ready  kind, entry_index, ticket_count,
//                                              eligible, random_value
//   rsp_     out        rsp_valid & rsp_ready  winner_index, ticket_pool,
//                                              none_eligible
//
// A set transfer writes one cell; the next request is taken
// in the following cycle.
// A pick makes one full turn of the cell ring to sum the tickets, reduces the
// random word by the total in the serial modulo unit (a start, then one step per
// bit of the 32-bit word), makes a second full turn to find the winner, and then
// loads the output register. A zero total skips the modulo and the second turn.
// The next request is taken in the cycle after the response is loaded.
// Reset is synchronous and clears every cell, the control state, the response
// valid flag and winner index; no request is taken while reset is high.
// The response sits in an output register; set transfers are taken while it
// waits, and a pick in flight holds its result until that register is free.
module lottery_process_selector #(
   parameter int NUM_ENTRIES = 64,
   parameter int TICKET_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_kind,
   input  logic [lps_pkg::IDX_IN_W-1:0]    req_entry_index,
   input  logic [lps_pkg::TICKET_IN_W-1:0] req_ticket_count,
   input  logic                            req_eligible,
   input  logic [lps_pkg::WORD_W-1:0]      req_random_value,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [lps_pkg::IDX_OUT_W-1:0]   rsp_winner_index,
   output logic [lps_pkg::TOTAL_OUT_W-1:0] rsp_ticket_pool,
   output logic                            rsp_none_eligible
);
   import lps_pkg::*;

   // Tickets beyond the port width can never be written, so cells store the narrower.
   localparam int STORE_W   = (TICKET_BITS < TICKET_IN_W) ? TICKET_BITS : TICKET_IN_W;
   localparam int IDX_W     = $clog2(NUM_ENTRIES);
   localparam int SUM_W     = IDX_W + STORE_W;
   localparam int TOT_EXT_W = SUM_W + TOTAL_OUT_W;
   localparam int WIN_EXT_W = IDX_W + IDX_OUT_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SUM  = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_FIND = 3'd3;
   localparam logic [2:0] ST_SEND = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [SUM_W-1:0] acc_ff, acc_in;
   logic [SUM_W-1:0] total_ff, total_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] win_ff, win_in;
   logic             none_ff, none_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [IDX_OUT_W-1:0]   current_index_ff, current_index_in;
   logic [TOTAL_OUT_W-1:0] rsp_total_ff, rsp_total_in;
   logic                   rsp_none_ff, rsp_none_in;

   logic [STORE_W-1:0] cell_ticket [NUM_ENTRIES];
   logic               cell_eligible [NUM_ENTRIES];

   logic               req_fire;
   logic               set_fire;
   logic               scan_active;
   logic               last_pos;
   logic [SUM_W-1:0]   head_add;
   logic [SUM_W-1:0]   acc_sum;
   logic               load_rsp;
   mod_ctrl_type       mod_ctrl;
   logic               mod_done;
   logic [SUM_W-1:0]   mod_remainder;
   logic [TOT_EXT_W-1:0] total_ext;
   logic [WIN_EXT_W-1:0] win_ext;

   assign req_ready   = (state_ff == ST_IDLE) && !reset;
   assign req_fire    = req_valid && req_ready;
   assign set_fire    = req_fire && (req_kind == KIND_SET);
   assign scan_active = (state_ff == ST_SUM) || (state_ff == ST_FIND);
   assign last_pos    = pos_ff == IDX_W'(NUM_ENTRIES - 1);

   // Cell 0 is the head of the ring; each cycle of a scan rotates one entry into it.
   assign head_add = cell_eligible[0] ? SUM_W'(cell_ticket[0]) : '0;
   assign acc_sum  = acc_ff + head_add;

   // Entry ring: cell i takes from cell i+1, the last cell from cell 0.
   for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cell
      cell_ctrl_type ctrl;
      assign ctrl.write = set_fire && (32'(req_entry_index) == i);
      assign ctrl.shift = scan_active;
      lps_cell #(
         .TICKET_W (STORE_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .wr_ticket   (req_ticket_count[STORE_W-1:0]),
         .wr_eligible (req_eligible),
         .nb_ticket   (cell_ticket[(i + 1) % NUM_ENTRIES]),
         .nb_eligible (cell_eligible[(i + 1) % NUM_ENTRIES]),
         .ticket      (cell_ticket[i]),
         .eligible    (cell_eligible[i])
      );
   end

   lps_mod_unit #(
      .DIVISOR_W (SUM_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (mod_ctrl),
      .dividend  (req_random_value),
      .divisor   (total_ff),
      .done      (mod_done),
      .remainder (mod_remainder)
   );

   // Latch the random word as the pick is taken; start the reduction once the total is known.
   assign mod_ctrl.load  = req_fire && (req_kind == KIND_PICK);
   assign mod_ctrl.start = (state_ff == ST_SUM) && last_pos && (acc_sum != '0);

   assign load_rsp = (state_ff == ST_SEND) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      acc_in   = acc_ff;
      total_in = total_ff;
      found_in = found_ff;
      win_in   = win_ff;
      none_in  = none_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_kind == KIND_PICK)) begin
               state_in = ST_SUM;
               pos_in   = '0;
               acc_in   = '0;
            end
         end
         ST_SUM: begin
            acc_in = acc_sum;
            pos_in = pos_ff + IDX_W'(1);
            if (last_pos) begin
               // ring is back in place; a zero total needs no draw
               pos_in   = '0;
               total_in = acc_sum;
               none_in  = (acc_sum == '0);
               win_in   = '0;
               state_in = (acc_sum == '0) ? ST_SEND : ST_DIV;
            end
         end
         ST_DIV: begin
            if (mod_done) begin
               state_in = ST_FIND;
               pos_in   = '0;
               acc_in   = '0;
               found_in = 1'b0;
            end
         end
         ST_FIND: begin
            acc_in = acc_sum;
            pos_in = pos_ff + IDX_W'(1);
            // first eligible entry whose running sum passes the draw wins
            if (!found_ff && cell_eligible[0] && (acc_sum > mod_remainder)) begin
               found_in = 1'b1;
               win_in   = pos_ff;
            end
            // finish the turn so the ring realigns for the next write
            if (last_pos) begin
               pos_in   = '0;
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign total_ext = TOT_EXT_W'(total_ff);
   assign win_ext   = WIN_EXT_W'(win_ff);

   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      current_index_in = current_index_ff;
      rsp_total_in     = rsp_total_ff;
      rsp_none_in      = rsp_none_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in     = 1'b1;
         current_index_in = win_ext[IDX_OUT_W-1:0];
         rsp_total_in     = total_ext[TOTAL_OUT_W-1:0];
         rsp_none_in      = none_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         current_index_ff <= '0;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         current_index_ff <= current_index_in;
      end
      pos_ff       <= pos_in;
      acc_ff       <= acc_in;
      total_ff     <= total_in;
      found_ff     <= found_in;
      win_ff       <= win_in;
      none_ff      <= none_in;
      rsp_total_ff <= rsp_total_in;
      rsp_none_ff  <= rsp_none_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_winner_index  = current_index_ff;
   assign rsp_ticket_pool   = rsp_total_ff;
   assign rsp_none_eligible = rsp_none_ff;

endmodule

// ===== rtl/core/lps_cell.sv =====
// One cell of the entry ring: ticket count and eligible mark of one entry.
// Depends on lps_pkg for the control struct.
module lps_cell #(
   parameter int TICKET_W = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lps_pkg::cell_ctrl_type ctrl,
   input  logic [TICKET_W-1:0]   wr_ticket,
   input  logic                  wr_eligible,
   input  logic [TICKET_W-1:0]   nb_ticket,
   input  logic                  nb_eligible,
   output logic [TICKET_W-1:0]   ticket,
   output logic                  eligible
);

   logic [TICKET_W-1:0] ticket_ff, ticket_in;
   logic                eligible_ff, eligible_in;

   always_comb begin
      ticket_in   = ticket_ff;
      eligible_in = eligible_ff;
      priority if (ctrl.write) begin
         ticket_in   = wr_ticket;
         eligible_in = wr_eligible;
      end else if (ctrl.shift) begin
         ticket_in   = nb_ticket;
         eligible_in = nb_eligible;
      end else begin
         // hold the entry
         ticket_in   = ticket_ff;
         eligible_in = eligible_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticket_ff   <= '0;
         eligible_ff <= 1'b0;
      end else begin
         ticket_ff   <= ticket_in;
         eligible_ff <= eligible_in;
      end
   end

   assign ticket   = ticket_ff;
   assign eligible = eligible_ff;

endmodule

// ===== rtl/core/lps_mod_unit.sv =====
// Bit-serial modulo unit: reduces a 32-bit word by a divisor, one bit per cycle.
// Depends on lps_pkg for the word width and the control struct.
module lps_mod_unit #(
   parameter int DIVISOR_W = 22
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lps_pkg::mod_ctrl_type     ctrl,
   input  logic [lps_pkg::WORD_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]      divisor,
   output logic                      done,
   output logic [DIVISOR_W-1:0]      remainder
);
   import lps_pkg::*;

   localparam int CNT_W = $clog2(WORD_W);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [WORD_W-1:0]    dvd_ff, dvd_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W:0]   diff;
   logic                 fits;

   assign trial = {rem_ff, dvd_ff[WORD_W-1]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      if (ctrl.load) begin
         dvd_in = dividend;
      end
      if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so one compare and subtract does
         rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         dvd_in = {dvd_ff[WORD_W-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(WORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/core/lps_checker.sv =====
// Port-level checks of the lottery process selector, bound to the top level.
// Depends on lps_pkg and lottery_process_selector.
module lps_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            req_kind,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [lps_pkg::IDX_OUT_W-1:0]   rsp_winner_index,
   input logic [lps_pkg::TOTAL_OUT_W-1:0] rsp_ticket_pool,
   input logic                            rsp_none_eligible
);
   import lps_pkg::*;

   // a waiting response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_winner_index) && $stable(rsp_ticket_pool)
         && $stable(rsp_none_eligible))
      else $error("response dropped or changed while stalled");

   // an empty draw reports entry 0 and a zero total
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_none_eligible |->
         (rsp_winner_index == '0) && (rsp_ticket_pool == '0))
      else $error("no eligible entry but non-zero winner or total");

   // a pick occupies the block: no request in the next cycle
   a_pick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == KIND_PICK) |=> !req_ready)
      else $error("request taken right after a pick");

   // no response appears in the cycle after any request transfer
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response raised too early");

endmodule

bind lottery_process_selector lps_checker u_lps_checker (.*);
